// File: hdl/brf_pkg.sv
// Shared types, widths and opcodes of the circular byte queue.
package brf_pkg;

	localparam int unsigned DEPTH_DEF = 4096;
	localparam int unsigned CAP_RESET = 4096;
	localparam int unsigned CAP_W     = 13;
	localparam int unsigned CNT_W     = 13;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned STAT_W    = 12;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_ADV_RD  = 3'd3,
		OP_ADV_WR  = 3'd4,
		OP_CLEAR   = 3'd5
	} brf_op_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [BYTE_W-1:0] push_byte;
		logic [CNT_W-1:0]  count;
	} brf_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              ok;
		logic [STAT_W-1:0] used_count;
		logic [STAT_W-1:0] free_count;
		logic [STAT_W-1:0] write_span;
		logic [STAT_W-1:0] read_span;
	} brf_rsp_t;

endpackage

// File: hdl/brf_cmd_if.sv
// Request channel of the circular byte queue.
interface brf_cmd_if;
	import brf_pkg::*;

	logic     valid;
	logic     ready;
	brf_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/brf_rsp_if.sv
// Response channel of the circular byte queue.
interface brf_rsp_if;
	import brf_pkg::*;

	logic     valid;
	logic     ready;
	brf_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/byte_ring_fifo_core.sv
// Circular byte queue with one slot kept empty, built around one byte memory.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------------
//  cmd       | in  | valid / ready      | opcode, push_byte, count
//  rsp       | out | valid / ready      | read_byte, ok, used/free counts, spans
//  cfg       | in  | cfg_we (no ready)  | cfg_wdata = ring size, clears the pointers
//
//  Cycles: one request per cycle sustained while responses are taken; a response
//  is valid once its request has passed both register stages: the registered
//  memory read loads when the request is taken, then the response register.
//  Reset: pointers and the used count clear at once; the byte memory is not
//  cleared and needs no clearing pass, so requests are taken right after reset.
//  Stalls: a stalled response holds in its register; one more request sits in
//  the read stage, then cmd.ready drops until the response is taken.
module byte_ring_fifo_core #(
	parameter int unsigned DEPTH = brf_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [brf_pkg::CAP_W-1:0] cfg_wdata,
	brf_cmd_if.sink                   cmd,
	brf_rsp_if.source                 rsp
);
	import brf_pkg::*;

	// pointer width, working width for compares against count, sum width
	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = (PW + 1 > CNT_W) ? PW + 1 : CNT_W;
	localparam int unsigned SW = CW + 1;
	localparam int unsigned SIZE_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

	// --- architectural state ---
	logic [PW:0]   size_q;     // clamped ring size, 2..DEPTH
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] used_q;     // bytes stored, kept alongside the pointers

	// byte memory, one write and one registered read per cycle
	logic [BYTE_W-1:0] mem [DEPTH];

	// --- read stage (memory data arrives here) ---
	logic              valid_s1;
	logic              ok_s1;
	logic              rd_sel_s1;   // response carries the memory byte
	logic [BYTE_W-1:0] rdata_s1;

	// --- response register ---
	logic     rsp_valid_q;
	brf_rsp_t rsp_q;

	// handshake
	logic accept;
	logic move_s1;

	assign move_s1   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || move_s1;
	assign accept    = cmd.valid && cmd.ready;

	// free slots from the current state
	logic [PW:0]   free_w;
	logic [PW-1:0] free_b;

	assign free_w = size_q - (PW + 1)'(1) - {1'b0, used_q};
	assign free_b = free_w[PW-1:0];

	// --- request decode ---
	logic [CW-1:0] cnt_w;
	logic          op_ok;
	logic          wr_side;     // wrap unit works on the write pointer
	logic          unit_step;   // step is one rather than count
	logic          do_push;
	logic          do_read;     // pop or peek, byte comes from memory
	logic          set_rd;
	logic          set_wr;
	logic          do_clear;
	logic [PW-1:0] used_d;

	assign cnt_w = CW'(cmd.data.count);

	always_comb begin
		op_ok     = 1'b0;
		wr_side   = 1'b0;
		unit_step = 1'b0;
		do_push   = 1'b0;
		do_read   = 1'b0;
		set_rd    = 1'b0;
		set_wr    = 1'b0;
		do_clear  = 1'b0;
		used_d    = used_q;
		case (cmd.data.opcode)
			OP_PUSH: begin
				op_ok     = (free_b != '0);
				wr_side   = 1'b1;
				unit_step = 1'b1;
				do_push   = op_ok;
				set_wr    = op_ok;
				used_d    = used_q + PW'(1);
			end
			OP_POP: begin
				op_ok     = (used_q != '0);
				unit_step = 1'b1;
				do_read   = op_ok;
				set_rd    = op_ok;
				used_d    = used_q - PW'(1);
			end
			OP_PEEK: begin
				op_ok   = (cnt_w < CW'(used_q));
				do_read = op_ok;
			end
			OP_ADV_RD: begin
				op_ok  = (cnt_w <= CW'(used_q));
				set_rd = op_ok;
				used_d = used_q - PW'(cmd.data.count);
			end
			OP_ADV_WR: begin
				op_ok   = (cnt_w <= CW'(free_b));
				wr_side = 1'b1;
				set_wr  = op_ok;
				used_d  = used_q + PW'(cmd.data.count);
			end
			OP_CLEAR: begin
				op_ok    = 1'b1;
				do_clear = 1'b1;
				used_d   = '0;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	// shared wrap unit: step stays below twice the ring size, so one
	// compare and subtract brings the sum back into the ring
	logic [SW-1:0] wrap_sum;
	logic [SW-1:0] wrap_fix;
	logic [PW-1:0] wrap_ptr;

	assign wrap_sum = SW'(wr_side ? wr_ptr_q : rd_ptr_q)
		+ (unit_step ? SW'(1) : SW'(cmd.data.count));
	assign wrap_fix = (wrap_sum >= SW'(size_q)) ? wrap_sum - SW'(size_q) : wrap_sum;
	assign wrap_ptr = wrap_fix[PW-1:0];

	// pop reads at the read pointer, peek at the wrapped offset
	logic [PW-1:0] rd_addr;
	assign rd_addr = (cmd.data.opcode == OP_POP) ? rd_ptr_q : wrap_ptr;

	// clamp of a written ring size to 2..DEPTH
	logic [CW-1:0] cfg_w;
	logic [PW:0]   size_d;

	assign cfg_w = CW'(cfg_wdata);

	always_comb begin
		if (cfg_w < CW'(2)) begin
			size_d = (PW + 1)'(2);
		end else if (cfg_w > CW'(DEPTH)) begin
			size_d = (PW + 1)'(DEPTH);
		end else begin
			size_d = cfg_w[PW:0];
		end
	end

	// pointer/count registers; user writes config only while idle, not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= (PW + 1)'(SIZE_RST);
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			used_q   <= '0;
		end else if (cfg_we) begin
			size_q   <= size_d;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			used_q   <= '0;
		end else if (accept && op_ok) begin
			used_q <= used_d;
			if (do_clear) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end
			if (set_rd) begin
				rd_ptr_q <= wrap_ptr;
			end
			if (set_wr) begin
				wr_ptr_q <= wrap_ptr;
			end
		end
	end

	// byte memory: push writes at the write pointer, every request reads.
	// The read taken with a push is dropped, and a pop or peek on the next
	// edge already sees the pushed byte, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			mem[wr_ptr_q] <= cmd.data.push_byte;
		end
		if (accept) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1     <= op_ok;
			rd_sel_s1 <= do_read;
		end
	end

	// status from the state left by the request now in the read stage;
	// a request taken on the same edge only changes the state afterwards
	logic [PW:0]   wspan_w;
	logic [PW:0]   rspan_w;
	logic          rd_ahead;

	assign rd_ahead = (rd_ptr_q > wr_ptr_q);

	always_comb begin
		if (free_b == '0) begin
			wspan_w = '0;
		end else if (rd_ahead) begin
			wspan_w = {1'b0, rd_ptr_q} - {1'b0, wr_ptr_q} - (PW + 1)'(1);
		end else if (rd_ptr_q == '0) begin
			// slot before slot zero must stay empty
			wspan_w = size_q - {1'b0, wr_ptr_q} - (PW + 1)'(1);
		end else begin
			wspan_w = size_q - {1'b0, wr_ptr_q};
		end
		if (rd_ahead) begin
			rspan_w = size_q - {1'b0, rd_ptr_q};
		end else begin
			rspan_w = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (move_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			rsp_q.read_byte  <= rd_sel_s1 ? rdata_s1 : '0;
			rsp_q.ok         <= ok_s1;
			rsp_q.used_count <= STAT_W'(used_q);
			rsp_q.free_count <= STAT_W'(free_b);
			rsp_q.write_span <= STAT_W'(wspan_w);
			rsp_q.read_span  <= STAT_W'(rspan_w);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// File: hdl/brf_checker.sv
// Port-level checks of the circular byte queue, bound to the top level.
module brf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [brf_pkg::BYTE_W-1:0] read_byte,
	input logic                       ok,
	input logic [brf_pkg::STAT_W-1:0] used_count,
	input logic [brf_pkg::STAT_W-1:0] free_count,
	input logic [brf_pkg::STAT_W-1:0] write_span,
	input logic [brf_pkg::STAT_W-1:0] read_span
);
	import brf_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(ok)
			&& $stable(used_count))
		else $error("stalled response changed");

	// refused requests return no byte
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> read_byte == '0)
		else $error("refused request returned a byte");

	// empty queue has nothing contiguous to read
	a_empty_span: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && used_count == '0 |-> read_span == '0)
		else $error("read span on empty queue");

	// full queue has nothing contiguous to write
	a_full_span: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && free_count == '0 |-> write_span == '0)
		else $error("write span on full queue");

endmodule

bind byte_ring_fifo_core brf_checker u_brf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_byte  (rsp.data.read_byte),
	.ok         (rsp.data.ok),
	.used_count (rsp.data.used_count),
	.free_count (rsp.data.free_count),
	.write_span (rsp.data.write_span),
	.read_span  (rsp.data.read_span)
);

// File: dv/brf_ring_checker.sv
// Checker for the circular byte queue: predicts each ring status reply and compares it.
module brf_ring_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [brf_pkg::CAP_W-1:0] cfg_wdata,
	brf_cmd_if                        cmd,
	brf_rsp_if                        rsp,
	output int                        outstanding,
	output int                        mismatches
);
	import brf_pkg::*;

	logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
	int unsigned       rd_pos   = 0;
	int unsigned       wr_pos   = 0;
	logic [CAP_W-1:0]  size_reg = CAP_W'(CAP_RESET);
	brf_rsp_t          due_status_q[$];
	int                due  = 0;
	int                errs = 0;

	assign outstanding = due;
	assign mismatches  = errs;

	// size register clamped to [2, DEPTH]
	function automatic int unsigned ring_slots();
		if (size_reg < 2) return 2;
		if (size_reg > DEPTH_DEF) return DEPTH_DEF;
		return size_reg;
	endfunction

	// applies one request to the ring and returns the status it should report
	function automatic brf_rsp_t apply_ring_op(brf_cmd_t c);
		int unsigned slots, used, room, wspan, rspan;
		brf_rsp_t    r;
		slots = ring_slots();
		used  = (wr_pos >= rd_pos) ? wr_pos - rd_pos : slots - (rd_pos - wr_pos);
		room  = slots - 1 - used;
		r     = '0;
		case (c.opcode)
			OP_PUSH: if (room > 0) begin
				ring_mem[wr_pos] = c.push_byte;
				wr_pos = (wr_pos + 1) % slots;
				r.ok = 1'b1;
			end
			OP_POP: if (used > 0) begin
				r.read_byte = ring_mem[rd_pos];
				rd_pos = (rd_pos + 1) % slots;
				r.ok = 1'b1;
			end
			OP_PEEK: if (c.count < used) begin
				r.read_byte = ring_mem[(rd_pos + c.count) % slots];
				r.ok = 1'b1;
			end
			OP_ADV_RD: if (c.count <= used) begin
				rd_pos = (rd_pos + c.count) % slots;
				r.ok = 1'b1;
			end
			OP_ADV_WR: if (c.count <= room) begin
				wr_pos = (wr_pos + c.count) % slots;
				r.ok = 1'b1;
			end
			OP_CLEAR: begin
				rd_pos = 0;
				wr_pos = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		used = (wr_pos >= rd_pos) ? wr_pos - rd_pos : slots - (rd_pos - wr_pos);
		room = slots - 1 - used;
		if (room == 0)
			wspan = 0;
		else if (rd_pos > wr_pos)
			wspan = rd_pos - wr_pos - 1;
		else if (rd_pos == 0)
			wspan = slots - wr_pos - 1;
		else
			wspan = slots - wr_pos;
		rspan = (rd_pos > wr_pos) ? slots - rd_pos : wr_pos - rd_pos;
		r.used_count = STAT_W'(used);
		r.free_count = STAT_W'(room);
		r.write_span = STAT_W'(wspan);
		r.read_span  = STAT_W'(rspan);
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		brf_rsp_t want;
		if (!arst_n) begin
			rd_pos   = 0;
			wr_pos   = 0;
			size_reg = CAP_W'(CAP_RESET);
			due_status_q.delete();
			due <= 0;
		end else begin
			if (cfg_we) begin
				size_reg = cfg_wdata;
				rd_pos   = 0;
				wr_pos   = 0;
			end
			if (cmd.valid && cmd.ready)
				due_status_q.push_back(apply_ring_op(cmd.data));
			if (rsp.valid && rsp.ready) begin
				if (due_status_q.size() == 0) begin
					$error("reply with no request outstanding");
					errs++;
				end else begin
					want = due_status_q.pop_front();
					check_field("read_byte",  16'(want.read_byte),  16'(rsp.data.read_byte));
					check_field("ok",         16'(want.ok),         16'(rsp.data.ok));
					check_field("used_count", 16'(want.used_count), 16'(rsp.data.used_count));
					check_field("free_count", 16'(want.free_count), 16'(rsp.data.free_count));
					check_field("write_span", 16'(want.write_span), 16'(rsp.data.write_span));
					check_field("read_span",  16'(want.read_span),  16'(rsp.data.read_span));
				end
			end
			due <= due_status_q.size();
		end
	end

endmodule

// File: dv/tb.sv
// Testbench top: drives requests and ring size writes, stalls replies, reports the verdict.
module tb;
	import brf_pkg::*;

	// opcodes the block must ignore
	localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

	localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
	localparam int DRAIN_CYCLES = 6;     // margin after the last reply is taken
	localparam int PHASES       = 14;
	localparam int PHASE_ITEMS  = 110;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	brf_cmd_if cmd_ch ();
	brf_rsp_if rsp_ch ();

	int outstanding;
	int mismatches;

	// Light shadow of the pointers, used only to steer stimulus: pops and peeks
	// must never land on a slot that was never written since reset.
	int unsigned      trk_rd   = 0;
	int unsigned      trk_wr   = 0;
	logic [CAP_W-1:0] trk_size = CAP_W'(CAP_RESET);
	bit               trk_wrote [DEPTH_DEF];

	bit send_quiet  = 1'b0;   // stretches with back-to-back requests
	bit take_quiet  = 1'b0;   // stretches with no reply stalls
	int stall_left  = 0;
	int idle_cycles = 0;

	byte_ring_fifo_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	brf_ring_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned trk_slots();
		if (trk_size < 2) return 2;
		if (trk_size > DEPTH_DEF) return DEPTH_DEF;
		return trk_size;
	endfunction

	function automatic int unsigned trk_used();
		return (trk_wr >= trk_rd) ? trk_wr - trk_rd : trk_slots() - (trk_rd - trk_wr);
	endfunction

	// pointer effects of an accepted request; refused ones leave the shadow alone
	function automatic void note_request(brf_cmd_t c);
		int unsigned slots, used, room;
		slots = trk_slots();
		used  = trk_used();
		room  = slots - 1 - used;
		case (c.opcode)
			OP_PUSH: if (room > 0) begin
				trk_wrote[trk_wr] = 1'b1;
				trk_wr = (trk_wr + 1) % slots;
			end
			OP_POP:    if (used > 0) trk_rd = (trk_rd + 1) % slots;
			OP_ADV_RD: if (c.count <= used) trk_rd = (trk_rd + c.count) % slots;
			OP_ADV_WR: if (c.count <= room) trk_wr = (trk_wr + c.count) % slots;
			OP_CLEAR: begin
				trk_rd = 0;
				trk_wr = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic brf_cmd_t mk_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
			logic [CNT_W-1:0] n);
		brf_cmd_t c;
		c.opcode    = op;
		c.push_byte = b;
		c.count     = n;
		return c;
	endfunction

	// Random request. Counts for the advance and peek operations mostly sit
	// around the legal limit so both the accepted and the refused side get hit;
	// the rest are raw 13-bit values so every count bit toggles.
	function automatic brf_cmd_t make_request();
		brf_cmd_t    c;
		int unsigned slots, used, room, pick;
		slots       = trk_slots();
		used        = trk_used();
		room        = slots - 1 - used;
		c.push_byte = BYTE_W'($urandom_range(0, 255));
		c.count     = CNT_W'($urandom_range(0, 8191));
		pick        = $urandom_range(0, 99);
		if (pick < 30) begin
			c.opcode = OP_PUSH;
		end else if (pick < 50) begin
			c.opcode = OP_POP;
			// head slot skipped over by an advance-write: step past it instead
			if (used > 0 && !trk_wrote[trk_rd]) begin
				c.opcode = OP_ADV_RD;
				c.count  = CNT_W'(1);
			end
		end else if (pick < 65) begin
			c.opcode = OP_PEEK;
			if ($urandom_range(0, 3) != 0)
				c.count = CNT_W'($urandom_range(0, used));
			if (c.count < used && !trk_wrote[(trk_rd + c.count) % slots])
				c.count = CNT_W'(used);
		end else if (pick < 77) begin
			c.opcode = OP_ADV_RD;
			if ($urandom_range(0, 4) != 0)
				c.count = CNT_W'($urandom_range(0, used + 1));
		end else if (pick < 89) begin
			c.opcode = OP_ADV_WR;
			if ($urandom_range(0, 4) != 0)
				c.count = CNT_W'($urandom_range(0, room + 1));
		end else if (pick < 96) begin
			c.opcode = OP_CLEAR;
		end else begin
			c.opcode = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
		end
		return c;
	endfunction

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (send_quiet || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one request and hold it until taken. valid gets a single
	// assignment per time step: lowered only for a gap ahead of the request.
	task automatic drive_request(input brf_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		note_request(c);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ring size may only change with the queue idle
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cmd_ch.valid <= 1'b0;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		trk_size = v;
		trk_rd   = 0;
		trk_wr   = 0;
	endtask

	// Reply side: random stalls, long ones now and then, calm stretches too.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (take_quiet || $urandom_range(0, 99) < 70) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			rsp_ch.ready <= 1'b0;
		end
		if ($urandom_range(0, 199) == 0)
			take_quiet = !take_quiet;
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[byte_ring_fifo_core] ERROR");
			$finish;
		end
	end

	initial begin
		logic [CAP_W-1:0] size_plan [PHASES];
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		rsp_ch.ready = 1'b0;

		// Ring sizes: clamped lows, the smallest real ring, full depth and the
		// values above it, plus a few random ones (mostly small).
		size_plan = '{13'd2, 13'd0, 13'd5, 13'd1, 13'd3, 13'd4096, 13'd8191, 13'd4097,
			13'd4095, CAP_W'($urandom_range(2, 40)), CAP_W'($urandom_range(2, 40)),
			CAP_W'($urandom_range(0, 8191)), 13'd2, CAP_W'($urandom_range(4, 300))};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at the reset size of 4096.
		// Empty queue: pop, peek and advance-read are refused; zero steps are fine.
		drive_request(mk_request(OP_POP,    8'h00, 13'd0));
		drive_request(mk_request(OP_PEEK,   8'h00, 13'd0));
		drive_request(mk_request(OP_ADV_RD, 8'h00, 13'd1));
		drive_request(mk_request(OP_ADV_RD, 8'h00, 13'd0));
		drive_request(mk_request(OP_ADV_WR, 8'h00, 13'd0));
		// data extremes
		drive_request(mk_request(OP_PUSH,   8'h00, 13'd0));
		drive_request(mk_request(OP_PUSH,   8'hFF, 13'd8191));
		drive_request(mk_request(OP_PUSH,   8'hA5, 13'd0));
		// peek inside, at the used count (refused) and far beyond
		drive_request(mk_request(OP_PEEK,   8'h00, 13'd0));
		drive_request(mk_request(OP_PEEK,   8'h00, 13'd2));
		drive_request(mk_request(OP_PEEK,   8'h00, 13'd3));
		drive_request(mk_request(OP_PEEK,   8'hFF, 13'd8191));
		drive_request(mk_request(OP_POP,    8'h00, 13'd0));
		drive_request(mk_request(OP_ADV_RD, 8'h00, 13'd2));
		// advance-write past the free count is refused; exactly the free count fills it
		drive_request(mk_request(OP_ADV_WR, 8'h00, 13'd8191));
		drive_request(mk_request(OP_ADV_WR, 8'h00, 13'd4095));
		// full: push refused, advance-read by more than used refused
		drive_request(mk_request(OP_PUSH,   8'h5A, 13'd0));
		drive_request(mk_request(OP_ADV_RD, 8'h00, 13'd4096));
		// unknown opcodes leave everything alone
		drive_request(mk_request(OP_UNDEF_A, 8'hFF, 13'd8191));
		drive_request(mk_request(OP_UNDEF_B, 8'h00, 13'd1));
		drive_request(mk_request(OP_CLEAR,  8'hFF, 13'd8191));

		// Random phases, one per ring size.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(size_plan[p]);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 39) == 0)
					send_quiet = !send_quiet;
				drive_request(make_request());
			end
		end

		cmd_ch.valid <= 1'b0;
		wait_drained();
		if (mismatches == 0)
			$display("[byte_ring_fifo_core] OK");
		else
			$display("[byte_ring_fifo_core] ERROR");
		$finish;
	end

endmodule

// File: files.f
hdl/brf_pkg.sv
hdl/brf_cmd_if.sv
hdl/brf_rsp_if.sv
hdl/byte_ring_fifo_core.sv
hdl/brf_checker.sv
dv/brf_ring_checker.sv
dv/tb.sv
